// ===== rtl/thl_pkg.sv =====
// shared types and constants for the touch hold ladder
package thl_pkg;

  localparam int unsigned THR_W   = 16;
  localparam int unsigned HOLD_W  = 13;
  localparam int unsigned PHASE_W = 9;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [THR_W-1:0]   THR_RESET    = THR_W'(55);
  localparam logic [HOLD_W-1:0]  MUTE_RESET   = HOLD_W'(2000);
  localparam logic [HOLD_W-1:0]  CONFIG_RESET = HOLD_W'(5000);
  localparam logic [HOLD_W-1:0]  HOLD_MAX     = HOLD_W'(8191);

  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(399);
  localparam logic [PHASE_W-1:0] SLOW_ON    = PHASE_W'(200);
  localparam logic [PHASE_W-1:0] FAST_ON    = PHASE_W'(100);
  localparam logic [PHASE_W-1:0] FAST_MOD   = PHASE_W'(200);
  localparam logic [PHASE_W-1:0] FAST_ON2   = PHASE_W'(300);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TOUCH_THRESHOLD = 2'd0,
    REG_MUTE_WINDOW     = 2'd1,
    REG_CONFIG_HOLD     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]  touch_threshold;
    logic [HOLD_W-1:0] mute_window_ms;
    logic [HOLD_W-1:0] config_hold_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic [PHASE_W-1:0] blink_phase;
    logic [HOLD_W-1:0]  hold_time;
    logic               touch_active;
    logic               config_fired;
    logic               led_held;
  } ctrl_state_t;

  typedef struct packed {
    logic start_config;
    logic mute_toggle;
    logic touch_marker;
    logic led_level;
  } result_t;

endpackage

// ===== rtl/touch_hold_ladder_top.sv =====
// top level of the touch hold ladder: registers, config port and stream handshake
// One tick request is taken per clock cycle while out_tready is high or no result is
// held, and its result appears in the output register on the next cycle; the single
// output register accepts a new request in the same cycle that the held result is
// taken. A reading below touch_threshold is a touch; the LED blinks slowly below
// mute_window_ms, fast up to config_hold_ms, then gives FLASH_COUNT flashes of
// FLASH_HALF_MS ticks on and off, ignoring touches, and pulses start_config on the
// last flash tick. Release from mute_window_ms up to config_hold_ms pulses mute_toggle.
// Configuration writes are always accepted; index 3 is ignored.
module touch_hold_ladder_top #(
  parameter int unsigned FLASH_COUNT   = 3,
  parameter int unsigned FLASH_HALF_MS = 50
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [thl_pkg::IN_DATA_W-1:0]      in_tdata,  // touch_value, server_active
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [thl_pkg::OUT_DATA_W-1:0]     out_tdata, // led_level, touch_marker,
                                                        // mute_toggle, start_config
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [thl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [thl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned FLW = $clog2(2 * FLASH_COUNT * FLASH_HALF_MS);
  localparam int unsigned SW  = $clog2(FLASH_HALF_MS + 1);

  thl_pkg::cfg_regs_t   cfg_r;
  thl_pkg::ctrl_state_t state_r;
  thl_pkg::ctrl_state_t state_nxt;
  logic [FLW-1:0]       flash_left_r;
  logic [FLW-1:0]       flash_left_nxt;
  logic [SW-1:0]        flash_sub_r;
  logic [SW-1:0]        flash_sub_nxt;
  logic                 flash_odd_r;
  logic                 flash_odd_nxt;
  thl_pkg::result_t     res_nxt;
  thl_pkg::result_t     res_r;
  logic                 out_valid_r;
  logic                 take;

  assign cfg_ready  = 1'b1;
  assign in_tready  = ~out_valid_r | out_tready;
  assign take       = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(thl_pkg::OUT_DATA_W - 4){1'b0}}, res_r};

  thl_core #(
    .FLASH_COUNT   (FLASH_COUNT),
    .FLASH_HALF_MS (FLASH_HALF_MS),
    .FLW           (FLW),
    .SW            (SW)
  ) u_core (
    .cfg               (cfg_r),
    .cur               (state_r),
    .flash_left        (flash_left_r),
    .flash_sub         (flash_sub_r),
    .flash_odd         (flash_odd_r),
    .touch_value       (in_tdata[thl_pkg::THR_W-1:0]),
    .server_active     (in_tdata[thl_pkg::THR_W]),
    .nxt               (state_nxt),
    .flash_left_nxt    (flash_left_nxt),
    .flash_sub_nxt     (flash_sub_nxt),
    .flash_odd_nxt     (flash_odd_nxt),
    .res               (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.touch_threshold <= thl_pkg::THR_RESET;
      cfg_r.mute_window_ms  <= thl_pkg::MUTE_RESET;
      cfg_r.config_hold_ms  <= thl_pkg::CONFIG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_addr)
        thl_pkg::REG_TOUCH_THRESHOLD: cfg_r.touch_threshold <= cfg_data;
        thl_pkg::REG_MUTE_WINDOW:     cfg_r.mute_window_ms  <= cfg_data[thl_pkg::HOLD_W-1:0];
        thl_pkg::REG_CONFIG_HOLD:     cfg_r.config_hold_ms  <= cfg_data[thl_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '0;
      flash_left_r <= '0;
      flash_sub_r  <= '0;
      flash_odd_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        state_r      <= state_nxt;
        flash_left_r <= flash_left_nxt;
        flash_sub_r  <= flash_sub_nxt;
        flash_odd_r  <= flash_odd_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/thl_core.sv =====
// next-state and result logic for one tick
module thl_core #(
  parameter int unsigned FLASH_COUNT   = 3,
  parameter int unsigned FLASH_HALF_MS = 50,
  parameter int unsigned FLW = $clog2(2 * FLASH_COUNT * FLASH_HALF_MS),
  parameter int unsigned SW  = $clog2(FLASH_HALF_MS + 1)
) (
  input  thl_pkg::cfg_regs_t           cfg,
  input  thl_pkg::ctrl_state_t         cur,
  input  logic [FLW-1:0]               flash_left,
  input  logic [SW-1:0]                flash_sub,
  input  logic                         flash_odd,
  input  logic [thl_pkg::THR_W-1:0]    touch_value,
  input  logic                         server_active,
  output thl_pkg::ctrl_state_t         nxt,
  output logic [FLW-1:0]               flash_left_nxt,
  output logic [SW-1:0]                flash_sub_nxt,
  output logic                         flash_odd_nxt,
  output thl_pkg::result_t             res
);

  localparam logic [FLW-1:0] FLASH_START = FLW'(2 * FLASH_COUNT * FLASH_HALF_MS - 1);
  localparam logic [SW-1:0]  SUB_LAST    = SW'(FLASH_HALF_MS - 1);
  localparam logic [SW-1:0]  SUB_INIT    = (FLASH_HALF_MS == 1) ? SW'(0) : SW'(1);
  localparam logic           ODD_INIT    = (FLASH_HALF_MS == 1);

  logic [thl_pkg::HOLD_W-1:0] hold_inc;
  logic [thl_pkg::HOLD_W-1:0] hold_sel;
  logic                       fired_sel;
  logic                       slow_on;
  logic                       fast_on;

  always_comb begin
    hold_inc = (cur.hold_time == thl_pkg::HOLD_MAX) ? cur.hold_time
                                                    : cur.hold_time + 1'b1;
    slow_on  = cur.blink_phase < thl_pkg::SLOW_ON;
    fast_on  = (cur.blink_phase < thl_pkg::FAST_ON) ||
               ((cur.blink_phase >= thl_pkg::FAST_MOD) &&
                (cur.blink_phase < thl_pkg::FAST_ON2));
    hold_sel  = cur.touch_active ? hold_inc : '0;
    fired_sel = cur.touch_active ? cur.config_fired : 1'b0;

    nxt            = cur;
    flash_left_nxt = flash_left;
    flash_sub_nxt  = flash_sub;
    flash_odd_nxt  = flash_odd;
    res.mute_toggle  = 1'b0;
    res.start_config = 1'b0;

    if (flash_left != '0) begin
      nxt.led_held   = ~flash_odd;
      flash_left_nxt = flash_left - 1'b1;
      nxt.hold_time  = hold_inc;
      if (flash_sub == SUB_LAST) begin
        flash_sub_nxt = '0;
        flash_odd_nxt = ~flash_odd;
      end else begin
        flash_sub_nxt = flash_sub + 1'b1;
      end
      if (flash_left == FLW'(1)) begin
        res.start_config = 1'b1;
        nxt.config_fired = 1'b1;
      end
    end else if (touch_value < cfg.touch_threshold) begin
      nxt.touch_active = 1'b1;
      nxt.hold_time    = hold_sel;
      nxt.config_fired = fired_sel;
      priority if (hold_sel < cfg.mute_window_ms) begin
        nxt.led_held = slow_on;
      end else if (hold_sel < cfg.config_hold_ms) begin
        nxt.led_held = fast_on;
      end else begin
        if (!fired_sel) begin
          nxt.led_held   = 1'b1;
          flash_left_nxt = FLASH_START;
          flash_sub_nxt  = SUB_INIT;
          flash_odd_nxt  = ODD_INIT;
        end
      end
    end else if (cur.touch_active) begin
      res.mute_toggle = (hold_inc >= cfg.mute_window_ms) &&
                        (hold_inc < cfg.config_hold_ms) && !cur.config_fired;
      nxt.led_held     = server_active;
      nxt.touch_active = 1'b0;
      nxt.config_fired = 1'b0;
      nxt.hold_time    = '0;
    end

    nxt.blink_phase = (cur.blink_phase == thl_pkg::PHASE_LAST) ? '0
                                                               : cur.blink_phase + 1'b1;
    res.led_level    = nxt.led_held;
    res.touch_marker = nxt.touch_active;
  end

endmodule
